// ----- rtl/mspwm_pkg.sv -----
// ----------------------------------------------------------------------------
// mspwm_pkg
// Types and constants shared by the multi-channel soft PWM scheduler.
// ----------------------------------------------------------------------------
package mspwm_pkg;

   localparam int TIME_W   = 16;
   localparam int DUTY_W   = 7;
   localparam int CHAN_W   = 3;
   localparam int MASK_W   = 8;
   localparam int COUNT_W  = 4;

   localparam int PROD_W   = TIME_W + DUTY_W;
   localparam int RECIP_W  = 24;
   localparam int QUOT_W   = PROD_W + RECIP_W;

   // floor(x / 100) = (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
   localparam logic [RECIP_W-1:0] DIV100_MUL   = 24'd10737419;
   localparam int                 DIV100_SHIFT = 30;

   localparam logic [TIME_W-1:0] NO_INTERVAL = 16'hFFFF;
   localparam logic [DUTY_W-1:0] DUTY_FULL   = 7'd100;

   localparam logic OP_ELAPSED  = 1'b0;
   localparam logic OP_SET_DUTY = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] high_time;
      logic [TIME_W-1:0] low_time;
      logic [TIME_W-1:0] remaining_time;
      logic              in_low_phase;
      logic [DUTY_W-1:0] last_duty;
   } chan_entry_type;

   typedef struct packed {
      chan_entry_type entry;
      logic           pin_write;
      logic           pin_level;
   } step_result_type;

endpackage

// ----- rtl/mspwm_step.sv -----
// ----------------------------------------------------------------------------
// mspwm_step
// Elapsed-interval update of one channel entry: saturating countdown,
// phase toggle on expiry and the resulting pin level.
// ----------------------------------------------------------------------------
module mspwm_step (
   input  mspwm_pkg::chan_entry_type        cur_entry,
   input  logic [mspwm_pkg::TIME_W-1:0]     interval,
   input  logic                             expiring,
   output mspwm_pkg::step_result_type       result
);
   import mspwm_pkg::*;

   logic [TIME_W-1:0] left;

   always_comb begin
      left = (cur_entry.remaining_time > interval) ?
             TIME_W'(cur_entry.remaining_time - interval) : '0;
      result                      = '0;
      result.entry                = cur_entry;
      result.entry.remaining_time = left;
      result.pin_write            = expiring;
      if (expiring) begin
         if (left == '0) begin
            result.entry.in_low_phase   = !cur_entry.in_low_phase;
            result.entry.remaining_time = cur_entry.in_low_phase ?
                                          cur_entry.high_time : cur_entry.low_time;
         end
         // no low time: reload the high time and drive the pin high
         if (cur_entry.low_time == '0) begin
            result.entry.remaining_time = cur_entry.high_time;
            result.pin_level            = 1'b1;
         end else begin
            result.pin_level = !result.entry.in_low_phase;
         end
      end
   end

endmodule

// ----- rtl/multi_channel_soft_pwm_scheduler.sv -----
// ----------------------------------------------------------------------------
// multi_channel_soft_pwm_scheduler
// Up to eight soft PWM channels sharing one interval timer; channel records
// sit in a memory with a registered read port, walked by a read-modify-write scan.
// ----------------------------------------------------------------------------
// requests: one at a time; a new request is taken only in the idle state, once the
//   previous result is in the response register, so the next item is taken while
//   that result waits. The elapsed scan reads one channel entry per cycle.
// reset: synchronous; per-entry valid bits make unwritten records read zero,
//   no clearing pass
module multi_channel_soft_pwm_scheduler #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [mspwm_pkg::COUNT_W-1:0]      csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [mspwm_pkg::CHAN_W-1:0]       req_channel,
   input  logic [mspwm_pkg::DUTY_W-1:0]       req_duty_percent,
   input  logic [mspwm_pkg::TIME_W-1:0]       req_period_ticks,
   input  logic                               req_timer_idle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mspwm_pkg::MASK_W-1:0]       rsp_pin_levels,
   output logic [mspwm_pkg::TIME_W-1:0]       rsp_next_interval,
   output logic [mspwm_pkg::MASK_W-1:0]       rsp_expiring_mask
);
   import mspwm_pkg::*;

   localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int USED_W = $clog2(MAX_CHANNELS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_WR   = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    op_ff, op_in;
   logic [CHAN_W-1:0]       ch_ff, ch_in;
   logic [DUTY_W-1:0]       duty_ff, duty_in;
   logic [TIME_W-1:0]       period_ff, period_in;
   logic                    idle_ff, idle_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [TIME_W-1:0]       hi_ff, hi_in;
   logic [MASK_W-1:0]       active_ff, active_in;
   logic [MASK_W-1:0]       pin_ff, pin_in;
   logic [TIME_W-1:0]       interval_ff, interval_in;
   logic [MASK_W-1:0]       set_ff, set_in;
   logic [USED_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                    pv_ff, pv_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic [TIME_W-1:0]       min_ff, min_in;
   logic [MASK_W-1:0]       acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]       rsp_pin_ff, rsp_pin_in;
   logic [TIME_W-1:0]       rsp_interval_ff, rsp_interval_in;
   logic [MASK_W-1:0]       rsp_mask_ff, rsp_mask_in;
   logic [MAX_CHANNELS-1:0] entry_valid_ff, entry_valid_in;
   logic                    rd_hit_ff, rd_hit_in;

   chan_entry_type          chan_mem [MAX_CHANNELS];
   chan_entry_type          rd_data_ff;
   chan_entry_type          rd_entry;
   chan_entry_type          wr_data;
   logic                    rd_en, wr_en;
   logic [IDX_W-1:0]        rd_addr, wr_addr;

   step_result_type         step;
   logic                    req_xfer;
   logic [USED_W-1:0]       used;
   logic [DUTY_W-1:0]       duty_sat;
   logic [QUOT_W-1:0]       quot_full;
   logic [MASK_W-1:0]       ch_bit;
   logic [MASK_W-1:0]       pidx_bit;
   logic [TIME_W-1:0]       scan_value;

   assign req_ready         = (state_ff == S_IDLE);
   assign req_xfer          = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_levels    = rsp_pin_ff;
   assign rsp_next_interval = rsp_interval_ff;
   assign rsp_expiring_mask = rsp_mask_ff;

   assign used      = (count_ff > COUNT_W'(MAX_CHANNELS)) ?
                      USED_W'(MAX_CHANNELS) : USED_W'(count_ff);
   assign duty_sat  = (req_duty_percent > DUTY_FULL) ? DUTY_FULL : req_duty_percent;
   assign quot_full = QUOT_W'(prod_ff) * QUOT_W'(DIV100_MUL);
   assign ch_bit    = MASK_W'(1) << ch_ff;
   assign pidx_bit  = MASK_W'(1) << pidx_ff;
   assign rd_entry  = rd_hit_ff ? rd_data_ff : '0;

   mspwm_step u_step (
      .cur_entry (rd_entry),
      .interval  (interval_ff),
      .expiring  (set_ff[pidx_ff]),
      .result    (step)
   );

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      op_in           = op_ff;
      ch_in           = ch_ff;
      duty_in         = duty_ff;
      period_in       = period_ff;
      idle_in         = idle_ff;
      prod_in         = prod_ff;
      hi_in           = hi_ff;
      active_in       = active_ff;
      pin_in          = pin_ff;
      interval_in     = interval_ff;
      set_in          = set_ff;
      rd_idx_in       = rd_idx_ff;
      pv_in           = pv_ff;
      pidx_in         = pidx_ff;
      min_in          = min_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_pin_in      = rsp_pin_ff;
      rsp_interval_in = rsp_interval_ff;
      rsp_mask_in     = rsp_mask_ff;
      entry_valid_in  = entry_valid_ff;
      rd_hit_in       = rd_hit_ff;
      rd_en           = 1'b0;
      rd_addr         = '0;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = rd_entry;
      scan_value      = rd_entry.remaining_time;

      if (csr_write_en) begin
         count_in = csr_write_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in     = req_op;
               ch_in     = req_channel;
               duty_in   = duty_sat;
               period_in = req_period_ticks;
               idle_in   = req_timer_idle;
               if (req_op == OP_SET_DUTY) begin
                  state_in = S_RD;
               end else begin
                  rd_idx_in = '0;
                  pv_in     = 1'b0;
                  min_in    = NO_INTERVAL;
                  acc_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ch_ff[IDX_W-1:0];
            prod_in  = PROD_W'(period_ff) * PROD_W'(duty_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            hi_in    = quot_full[DIV100_SHIFT +: TIME_W];
            state_in = S_WR;
         end
         S_WR: begin
            state_in = S_DONE;
            if ((COUNT_W'(ch_ff) < COUNT_W'(used)) && (duty_ff != rd_entry.last_duty)) begin
               wr_en                = 1'b1;
               wr_addr              = ch_ff[IDX_W-1:0];
               wr_data.high_time    = hi_ff;
               wr_data.low_time     = TIME_W'(period_ff - hi_ff);
               wr_data.last_duty    = duty_ff;
               // activation starts in the high phase
               if (rd_entry.last_duty == '0) begin
                  wr_data.remaining_time = hi_ff;
                  wr_data.in_low_phase   = 1'b0;
                  active_in              = active_in | ch_bit;
                  pin_in                 = pin_in | ch_bit;
               end
               if (duty_ff == '0) begin
                  active_in = active_in & ~ch_bit;
                  pin_in    = pin_in & ~ch_bit;
               end
               if (idle_ff) begin
                  rd_idx_in = '0;
                  pv_in     = 1'b0;
                  min_in    = NO_INTERVAL;
                  acc_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_idx_ff < used) begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff[IDX_W-1:0];
               rd_idx_in = rd_idx_ff + USED_W'(1);
               pidx_in   = rd_idx_ff[IDX_W-1:0];
               pv_in     = 1'b1;
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff && active_ff[pidx_ff]) begin
               if (op_ff == OP_ELAPSED) begin
                  wr_en      = 1'b1;
                  wr_addr    = pidx_ff;
                  wr_data    = step.entry;
                  scan_value = step.entry.remaining_time;
                  if (step.pin_write) begin
                     pin_in[pidx_ff] = step.pin_level;
                  end
               end
               // running minimum and the set of channels that reach it
               if (scan_value < min_ff) begin
                  min_in = scan_value;
                  acc_in = pidx_bit;
               end else if (scan_value == min_ff) begin
                  acc_in = acc_ff | pidx_bit;
               end
            end
            if ((rd_idx_ff >= used) && !pv_ff) begin
               interval_in = min_ff;
               set_in      = acc_ff;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_pin_in      = pin_ff;
               rsp_interval_in = interval_ff;
               rsp_mask_in     = set_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         entry_valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_hit_in = entry_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chan_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= chan_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         active_ff      <= '0;
         pin_ff         <= '0;
         interval_ff    <= NO_INTERVAL;
         set_ff         <= '0;
         rd_idx_ff      <= '0;
         pv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         rd_hit_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         active_ff      <= active_in;
         pin_ff         <= pin_in;
         interval_ff    <= interval_in;
         set_ff         <= set_in;
         rd_idx_ff      <= rd_idx_in;
         pv_ff          <= pv_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_valid_ff <= entry_valid_in;
         rd_hit_ff      <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      ch_ff           <= ch_in;
      duty_ff         <= duty_in;
      period_ff       <= period_in;
      idle_ff         <= idle_in;
      prod_ff         <= prod_in;
      hi_ff           <= hi_in;
      pidx_ff         <= pidx_in;
      min_ff          <= min_in;
      acc_ff          <= acc_in;
      rsp_pin_ff      <= rsp_pin_in;
      rsp_interval_ff <= rsp_interval_in;
      rsp_mask_ff     <= rsp_mask_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("scheduler idle right after an input transfer");

   a_empty_set_no_interval: assert property (@(posedge clock) disable iff (reset)
      (set_ff == '0) |-> (interval_ff == NO_INTERVAL))
      else $error("empty expiring set with a finite interval");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (USED_W'(pidx_ff) < used))
      else $error("scan touched a channel beyond the count");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of one channel record in one cycle");
`endif

endmodule

// ----- bench/multi_channel_soft_pwm_scheduler_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_soft_pwm_scheduler_test
// Self-checking bench for the soft PWM scheduler. A driver feeds set-duty and
// elapsed requests from a queue, and a per-transfer model of the channel table
// predicts pin levels, next interval and expiring set for every transfer.
// A monitor checks each response against the oldest prediction. Both sides
// insert random gaps. The channel count is rewritten between phases.
// ----------------------------------------------------------------------------
module multi_channel_soft_pwm_scheduler_test;
   import mspwm_pkg::*;

   localparam int          CHANNELS    = 8;
   localparam int unsigned CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] channel;
      logic [DUTY_W-1:0] duty;
      logic [TIME_W-1:0] period;
      logic              timer_idle;
   } pwm_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] pins;
      logic [TIME_W-1:0] interval;
      logic [MASK_W-1:0] expiring;
   } pwm_status_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                csr_write_en     = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_op           = OP_ELAPSED;
   logic [CHAN_W-1:0]   req_channel      = '0;
   logic [DUTY_W-1:0]   req_duty_percent = '0;
   logic [TIME_W-1:0]   req_period_ticks = '0;
   logic                req_timer_idle   = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [MASK_W-1:0]   rsp_pin_levels;
   logic [TIME_W-1:0]   rsp_next_interval;
   logic [MASK_W-1:0]   rsp_expiring_mask;

   multi_channel_soft_pwm_scheduler dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_channel       (req_channel),
      .req_duty_percent  (req_duty_percent),
      .req_period_ticks  (req_period_ticks),
      .req_timer_idle    (req_timer_idle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pin_levels    (rsp_pin_levels),
      .rsp_next_interval (rsp_next_interval),
      .rsp_expiring_mask (rsp_expiring_mask)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // channel table model
   logic [TIME_W-1:0]  chan_high   [CHANNELS];
   logic [TIME_W-1:0]  chan_low    [CHANNELS];
   logic [TIME_W-1:0]  chan_left   [CHANNELS];
   logic               chan_in_low [CHANNELS];
   logic [DUTY_W-1:0]  chan_duty   [CHANNELS];
   logic [MASK_W-1:0]  active_bits;
   logic [MASK_W-1:0]  pin_bits;
   logic [TIME_W-1:0]  interval_q;
   logic [MASK_W-1:0]  expiry_bits;
   logic [COUNT_W-1:0] chan_count_q;

   pwm_req_type    pending_q [$];
   pwm_status_type status_q  [$];
   pwm_req_type    cur_req;
   pwm_status_type want;

   int unsigned req_gap, rsp_stall;
   bit          send_burst, recv_burst;
   int unsigned err_count, set_count, elapsed_count, checked_count;
   int unsigned settings_count, cycle_count;

   function automatic int unsigned used_channels();
      int unsigned n;
      n = chan_count_q;
      if (n > CHANNELS) n = CHANNELS;
      return n;
   endfunction

   function automatic void find_next_expiry();
      int unsigned       n;
      logic [TIME_W-1:0] m;
      logic [MASK_W-1:0] s;
      n = used_channels();
      m = NO_INTERVAL;
      s = '0;
      for (int i = 0; i < n; i++)
         if (active_bits[i] && chan_left[i] < m) m = chan_left[i];
      for (int i = 0; i < n; i++)
         if (active_bits[i] && chan_left[i] == m) s[i] = 1'b1;
      interval_q  = m;
      expiry_bits = s;
   endfunction

   function automatic void apply_duty(input pwm_req_type r);
      logic [DUTY_W-1:0] duty;
      logic [31:0]       prod;
      logic [TIME_W-1:0] hi;
      int unsigned       ch;
      ch = r.channel;
      if (ch >= used_channels()) return;
      duty = (r.duty > DUTY_FULL) ? DUTY_FULL : r.duty;
      if (chan_duty[ch] == duty) return;
      prod = r.period * duty;
      hi   = TIME_W'(prod / DUTY_FULL);
      chan_high[ch] = hi;
      chan_low[ch]  = r.period - hi;
      if (chan_duty[ch] == '0) begin
         chan_left[ch]   = hi;
         chan_in_low[ch] = 1'b0;
         active_bits[ch] = 1'b1;
         pin_bits[ch]    = 1'b1;
      end
      if (duty == '0) begin
         pin_bits[ch]    = 1'b0;
         active_bits[ch] = 1'b0;
      end
      chan_duty[ch] = duty;
      if (r.timer_idle) find_next_expiry();
   endfunction

   function automatic void apply_elapsed();
      int unsigned n;
      n = used_channels();
      for (int i = 0; i < n; i++) begin
         if (!active_bits[i]) continue;
         if (chan_left[i] > interval_q) chan_left[i] = chan_left[i] - interval_q;
         else chan_left[i] = '0;
         if (!expiry_bits[i]) continue;
         if (chan_left[i] == '0) begin
            if (chan_in_low[i]) begin
               chan_left[i]   = chan_high[i];
               chan_in_low[i] = 1'b0;
            end else begin
               chan_left[i]   = chan_low[i];
               chan_in_low[i] = 1'b1;
            end
         end
         if (chan_low[i] == '0) begin
            chan_left[i] = chan_high[i];
            pin_bits[i]  = 1'b1;
         end else begin
            pin_bits[i] = !chan_in_low[i];
         end
      end
      find_next_expiry();
   endfunction

   function automatic pwm_status_type advance_pwm(input pwm_req_type r);
      pwm_status_type s;
      if (r.op == OP_SET_DUTY) apply_duty(r);
      else apply_elapsed();
      s.pins     = pin_bits;
      s.interval = interval_q;
      s.expiring = expiry_bits;
      return s;
   endfunction

   function automatic int unsigned next_gap(inout bit burst);
      int unsigned roll;
      if ($urandom_range(0, 49) == 0) burst = !burst;
      if (burst) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic pwm_req_type random_req();
      pwm_req_type r;
      int unsigned n, roll;
      n = used_channels();
      r.op = ($urandom_range(0, 99) < 55) ? OP_ELAPSED : OP_SET_DUTY;
      if (n > 0 && $urandom_range(0, 99) < 85) r.channel = CHAN_W'($urandom_range(0, n - 1));
      else r.channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 12) r.duty = '0;
      else if (roll < 20) r.duty = DUTY_FULL;
      else if (roll < 25) r.duty = DUTY_W'($urandom_range(101, 127));
      else r.duty = DUTY_W'($urandom_range(1, 99));
      roll = $urandom_range(0, 99);
      if (roll < 3) r.period = '0;
      else if (roll < 6) r.period = NO_INTERVAL;
      else if (roll < 15) r.period = TIME_W'($urandom_range(0, 65535));
      else r.period = TIME_W'($urandom_range(1, 400));
      r.timer_idle = ($urandom_range(0, 99) < 85);
      return r;
   endfunction

   task automatic add_req(input logic op, input int unsigned ch, input int unsigned duty,
                          input int unsigned period, input logic idle);
      pwm_req_type r;
      r.op         = op;
      r.channel    = CHAN_W'(ch);
      r.duty       = DUTY_W'(duty);
      r.period     = TIME_W'(period);
      r.timer_idle = idle;
      pending_q.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_channel_count(input logic [COUNT_W-1:0] value);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      chan_count_q = value;
      settings_count++;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] value, input int unsigned n_items);
      wait_drained();
      write_channel_count(value);
      repeat (n_items) pending_q.push_back(random_req());
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            status_q.push_back(advance_pwm(cur_req));
            if (cur_req.op == OP_SET_DUTY) set_count++;
            else elapsed_count++;
            req_gap = next_gap(send_burst);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               cur_req = pending_q.pop_front();
               req_op           <= cur_req.op;
               req_channel      <= cur_req.channel;
               req_duty_percent <= cur_req.duty;
               req_period_ticks <= cur_req.period;
               req_timer_idle   <= cur_req.timer_idle;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $error("response transfer with no prediction waiting");
               err_count++;
            end else begin
               want = status_q.pop_front();
               if (rsp_pin_levels !== want.pins) begin
                  $error("pin_levels: expected %h, actual %h", want.pins, rsp_pin_levels);
                  err_count++;
               end
               if (rsp_next_interval !== want.interval) begin
                  $error("next_interval: expected %0d, actual %0d",
                         want.interval, rsp_next_interval);
                  err_count++;
               end
               if (rsp_expiring_mask !== want.expiring) begin
                  $error("expiring_mask: expected %h, actual %h",
                         want.expiring, rsp_expiring_mask);
                  err_count++;
               end
            end
            checked_count++;
            rsp_stall = next_gap(recv_burst);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < CHANNELS; i++) begin
         chan_high[i]   = '0;
         chan_low[i]    = '0;
         chan_left[i]   = '0;
         chan_in_low[i] = 1'b0;
         chan_duty[i]   = '0;
      end
      active_bits  = '0;
      pin_bits     = '0;
      interval_q   = NO_INTERVAL;
      expiry_bits  = '0;
      chan_count_q = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all eight channels
      write_channel_count(COUNT_W'(CHANNELS));
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_SET_DUTY, 0,  50,  1000, 1'b1);
      add_req(OP_SET_DUTY, 0,  50,   777, 1'b1);   // same duty again
      add_req(OP_SET_DUTY, 1, 100,   300, 1'b1);   // zero low time
      add_req(OP_SET_DUTY, 2, 127, 65535, 1'b1);   // duty saturates
      add_req(OP_SET_DUTY, 7,   1, 65535, 1'b0);   // timer busy, no recompute
      add_req(OP_ELAPSED,  0,   0,     0, 1'b0);
      add_req(OP_SET_DUTY, 3,  50,     0, 1'b1);   // zero period
      add_req(OP_ELAPSED,  5, 127, 65535, 1'b1);   // zero interval
      add_req(OP_ELAPSED,  0,   0,     0, 1'b0);
      add_req(OP_SET_DUTY, 3,   0,     0, 1'b1);   // deactivate
      add_req(OP_SET_DUTY, 4,  99,     1, 1'b1);
      add_req(OP_SET_DUTY, 5,   1,   100, 1'b1);
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_SET_DUTY, 7,   0, 65535, 1'b1);
      add_req(OP_SET_DUTY, 6, 100,     0, 1'b1);
      add_req(OP_SET_DUTY, 0,  25,  1000, 1'b1);   // duty change while active
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);
      add_req(OP_ELAPSED,  0,   0,     0, 1'b1);

      run_phase(4'd8, 80);
      run_phase(4'd0, 20);
      run_phase(4'd15, 80);
      run_phase(4'd3, 75);
      run_phase(4'd1, 70);
      run_phase(COUNT_W'($urandom_range(2, 15)), 75);
      run_phase(4'd5, 75);
      run_phase(4'd8, 80);

      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      for (int k = 0; k < 2000 && status_q.size() != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (status_q.size() != 0) begin
         $error("%0d predicted responses never arrived", status_q.size());
         err_count += status_q.size();
      end

      $display("run covered %0d request transfers (%0d set-duty, %0d elapsed), %0d responses",
               set_count + elapsed_count, set_count, elapsed_count, checked_count);
      $display("channel count rewritten %0d times, including 0, 8 and 15; %0d errors",
               settings_count, err_count);
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mspwm_pkg.sv
rtl/mspwm_step.sv
rtl/multi_channel_soft_pwm_scheduler.sv
bench/multi_channel_soft_pwm_scheduler_test.sv
